[hdl/gate_step_sequencer_top_defines.svh]
// assertion macros for the gate step sequencer
`ifndef GATE_STEP_SEQUENCER_TOP_DEFINES_SVH
`define GATE_STEP_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define GSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gss_pkg.sv]
`default_nettype none

package gss_pkg;

   localparam int PERIOD_W   = 14;
   localparam int SWING_W    = 12;
   localparam int GATE_W     = 14;
   localparam int STEPS_W    = 5;
   localparam int TICK_W     = 16;
   localparam int HOLD_W     = 14;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 2;
   localparam int LINE_W     = 3;
   localparam int EFF_W      = PERIOD_W + 1;
   localparam int CALC_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [HOLD_W-1:0]  EXT_HOLD_TICKS  = 14'd10000;
   localparam logic [TICK_W-1:0]  STOP_PRELOAD    = 16'd10200;
   localparam logic [EFF_W-1:0]   MIN_GATE_MARGIN = 15'd4;
   localparam logic [STEPS_W-1:0] MIN_STEPS       = 5'd1;
   localparam logic [STEPS_W-1:0] MAX_STEPS       = 5'd16;
   localparam logic [STEPS_W-1:0] ROWS_PER_COL    = 5'd8;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 14'd500;
   localparam logic [SWING_W-1:0]  SWING_RESET      = 12'd0;
   localparam logic [GATE_W-1:0]   GATE_RESET       = 14'd250;
   localparam logic [STEPS_W-1:0]  STEP_COUNT_RESET = 5'd16;

   localparam logic [COL_W-1:0] COL_FIRST  = 2'b01;
   localparam logic [COL_W-1:0] COL_SECOND = 2'b10;
   localparam logic [COL_W-1:0] COL_BOTH   = 2'b11;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PERIOD     = 3'd0,
      REG_SWING      = 3'd1,
      REG_GATE_ON    = 3'd2,
      REG_GATE_OFF   = 3'd3,
      REG_STEP_COUNT = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_ticks;
      logic [SWING_W-1:0]  swing_ticks;
      logic [GATE_W-1:0]   gate_on_beat;
      logic [GATE_W-1:0]   gate_off_beat;
      logic [STEPS_W-1:0]  step_count;
   } cfg_type;

   // clock_in lands in bit 0
   typedef struct packed {
      logic mode_1x16;
      logic backward;
      logic not_held;
      logic run_enable;
      logic clock_in;
   } item_type;

   // row_lines lands in bits 2:0
   typedef struct packed {
      logic              step_advanced;
      logic              gate;
      logic [COL_W-1:0]  column_lines;
      logic [LINE_W-1:0] row_lines;
   } result_type;

endpackage

`default_nettype wire

[hdl/gss_csr.sv]
`default_nettype none

module gss_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [gss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output gss_pkg::cfg_type                    cfg
);
   import gss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_PERIOD:     cfg_in.period_ticks  = csr_wdata[PERIOD_W-1:0];
            REG_SWING:      cfg_in.swing_ticks   = csr_wdata[SWING_W-1:0];
            REG_GATE_ON:    cfg_in.gate_on_beat  = csr_wdata[GATE_W-1:0];
            REG_GATE_OFF:   cfg_in.gate_off_beat = csr_wdata[GATE_W-1:0];
            REG_STEP_COUNT: cfg_in.step_count    = csr_wdata[STEPS_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks  <= PERIOD_RESET;
         cfg_ff.swing_ticks   <= SWING_RESET;
         cfg_ff.gate_on_beat  <= GATE_RESET;
         cfg_ff.gate_off_beat <= GATE_RESET;
         cfg_ff.step_count    <= STEP_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/gss_core.sv]
`default_nettype none

module gss_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gss_pkg::cfg_type    cfg,
   input  wire gss_pkg::item_type   item,
   input  wire logic                fire,
   output gss_pkg::result_type      result
);
   import gss_pkg::*;

   logic [TICK_W-1:0]       tick_ff,  tick_in;
   logic [HOLD_W-1:0]       hold_ff,  hold_in;
   logic                    last_clk_ff, last_clk_in;
   logic signed [ROW_W-1:0] row_ff,   row_in;
   logic [COL_W-1:0]        col_sel_ff, col_sel_in;
   logic [COL_W-1:0]        col_drv_ff, col_drv_in;
   logic                    beat_ff,  beat_in;
   logic                    prev_mode_ff, prev_mode_in;

   logic [COL_W-1:0]         col_m;
   logic [STEPS_W-1:0]       steps_c;
   logic [STEPS_W-1:0]       last;
   logic [STEPS_W-1:0]       lim;
   logic [TICK_W-1:0]        tick_inc;
   logic                     clk_rise;
   logic [EFF_W-1:0]         eff_long;
   logic [EFF_W-1:0]         eff_short;
   logic [EFF_W-1:0]         eff_cur;
   logic [EFF_W-1:0]         eff_new;
   logic [HOLD_W-1:0]        hold_set;
   logic [HOLD_W-1:0]        hold_next;
   logic                     adv;
   logic signed [CALC_W-1:0] row_ext;
   logic signed [CALC_W-1:0] row_x;
   logic signed [CALC_W-1:0] row_w;
   logic signed [CALC_W-1:0] last_s;
   logic signed [CALC_W-1:0] lim_s;
   logic [COL_W-1:0]         col_w;
   logic                     beat_new;
   logic [TICK_W-1:0]        tick_new;
   logic [GATE_W-1:0]        gate_raw;
   logic [GATE_W-1:0]        gate_min;
   logic [EFF_W-1:0]         gate_top;
   logic [EFF_W-1:0]         gate_len;

   always_comb begin
      col_m = (item.mode_1x16 && !prev_mode_ff) ? COL_FIRST : col_sel_ff;

      if (cfg.step_count < MIN_STEPS) begin
         steps_c = MIN_STEPS;
      end else if (cfg.step_count > MAX_STEPS) begin
         steps_c = MAX_STEPS;
      end else begin
         steps_c = cfg.step_count;
      end
      last = item.mode_1x16 ? steps_c : (steps_c >> 1);
      lim  = (last < ROWS_PER_COL) ? last : ROWS_PER_COL;

      tick_inc = tick_ff + 1'b1;
      clk_rise = item.clock_in && !last_clk_ff;

      // effective beat length, short beat saturates at zero
      eff_long  = {1'b0, cfg.period_ticks} + {{(EFF_W-SWING_W){1'b0}}, cfg.swing_ticks};
      eff_short = (cfg.period_ticks >= {{(PERIOD_W-SWING_W){1'b0}}, cfg.swing_ticks})
                ? {1'b0, cfg.period_ticks} - {{(EFF_W-SWING_W){1'b0}}, cfg.swing_ticks}
                : '0;
      eff_cur = beat_ff ? eff_long : eff_short;

      hold_set  = clk_rise ? EXT_HOLD_TICKS : hold_ff;
      hold_next = (hold_set != '0) ? hold_set - 1'b1 : '0;
      adv = clk_rise || ((hold_next == '0) && (tick_inc >= {1'b0, eff_cur}));

      // step wrap
      row_ext = CALC_W'(row_ff);
      row_x   = item.backward ? row_ext - 7'sd1 : row_ext + 7'sd1;
      last_s  = signed'({2'b00, last});
      lim_s   = signed'({2'b00, lim});
      row_w   = row_x;
      col_w   = col_m;
      if (!item.mode_1x16) begin
         if (row_x >= last_s) begin
            row_w = '0;
         end else if (row_x < 7'sd0) begin
            row_w = last_s - 7'sd1;
         end
      end else if (col_m == COL_FIRST) begin
         if (row_x >= lim_s) begin
            col_w = (last <= ROWS_PER_COL) ? COL_FIRST : COL_SECOND;
            row_w = '0;
         end else if (row_x < 7'sd0) begin
            col_w = (last <= ROWS_PER_COL) ? COL_FIRST : COL_SECOND;
            row_w = (last <= ROWS_PER_COL) ? last_s - 7'sd1 : last_s - 7'sd9;
         end
      end else begin
         if (row_x + 7'sd8 >= last_s) begin
            col_w = COL_FIRST;
            row_w = '0;
         end else if (row_x < 7'sd0) begin
            col_w = COL_FIRST;
            row_w = 7'sd7;
         end
      end

      // gate length for the beat now in progress
      beat_new = adv ? !beat_ff : beat_ff;
      tick_new = adv ? '0 : tick_inc;
      eff_new  = beat_new ? eff_long : eff_short;
      gate_raw = beat_new ? cfg.gate_on_beat : cfg.gate_off_beat;
      gate_min = (gate_raw < GATE_W'(MIN_GATE_MARGIN)) ? GATE_W'(MIN_GATE_MARGIN) : gate_raw;
      gate_top = eff_new - MIN_GATE_MARGIN;
      if (eff_new < MIN_GATE_MARGIN) begin
         gate_len = '0;
      end else if ({1'b0, gate_min} > gate_top) begin
         gate_len = gate_top;
      end else begin
         gate_len = {1'b0, gate_min};
      end

      tick_in      = tick_ff;
      hold_in      = hold_ff;
      last_clk_in  = item.clock_in;
      row_in       = row_ff;
      col_sel_in   = col_m;
      col_drv_in   = col_drv_ff;
      beat_in      = beat_ff;
      prev_mode_in = item.mode_1x16;
      result.row_lines     = ~row_ff[LINE_W-1:0];
      result.column_lines  = col_m;
      result.gate          = 1'b0;
      result.step_advanced = 1'b0;

      if (!item.not_held) begin
         tick_in = STOP_PRELOAD;
         beat_in = 1'b1;
         if (item.backward) begin
            if (item.mode_1x16 && (last > ROWS_PER_COL)) begin
               row_in     = signed'(last - ROWS_PER_COL);
               col_sel_in = COL_SECOND;
            end else begin
               row_in     = signed'(last);
               col_sel_in = COL_FIRST;
            end
         end else begin
            row_in     = -5'sd1;
            col_sel_in = COL_FIRST;
         end
      end else if (!item.run_enable) begin
         tick_in    = STOP_PRELOAD;
         col_drv_in = item.mode_1x16 ? col_m : COL_BOTH;
         result.column_lines = col_drv_in;
         result.gate         = 1'b1;
      end else begin
         hold_in = hold_next;
         tick_in = tick_new;
         beat_in = beat_new;
         if (adv) begin
            row_in     = row_w[ROW_W-1:0];
            col_sel_in = col_w;
            col_drv_in = item.mode_1x16 ? col_w : COL_BOTH;
         end
         result.row_lines     = ~row_in[LINE_W-1:0];
         result.column_lines  = col_drv_in;
         result.gate          = (tick_new <= {1'b0, gate_len});
         result.step_advanced = adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         hold_ff      <= '0;
         last_clk_ff  <= 1'b0;
         row_ff       <= '0;
         col_sel_ff   <= COL_FIRST;
         col_drv_ff   <= COL_FIRST;
         beat_ff      <= 1'b1;
         prev_mode_ff <= 1'b0;
      end else if (fire) begin
         tick_ff      <= tick_in;
         hold_ff      <= hold_in;
         last_clk_ff  <= last_clk_in;
         row_ff       <= row_in;
         col_sel_ff   <= col_sel_in;
         col_drv_ff   <= col_drv_in;
         beat_ff      <= beat_in;
         prev_mode_ff <= prev_mode_in;
      end
   end

endmodule

`default_nettype wire

[hdl/gate_step_sequencer_top.sv]
// Gate step sequencer, one req beat per timer tick.
// req channel: each beat carries the clock, run, reset, direction and mode
// pin levels of one tick. rsp channel: one beat per req beat, in order, with
// the row address lines, column enables, gate level and step-advance flag.
// csr port: a write with csr_we high sets the register at csr_index; write
// only while no beat is in flight.
// A req beat passes through the input register, one pass of step/gate logic
// and the output register before it appears on rsp. Throughput: one beat per
// cycle while rsp_tready is high, as the core fires only when rsp can take it.
// Reset: all tick state returns to its power-up values, registers to their
// defaults, both channels empty.
// Stall: while rsp_tready is low the result is held; one further req beat is
// taken into the input register, then req_tready drops until rsp drains.
`default_nettype none

`include "gate_step_sequencer_top_defines.svh"

module gate_step_sequencer_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output wire logic                           req_tready,
   // clock_in, run_enable, not_held, backward, mode_1x16, zero pad
   input  wire logic [gss_pkg::REQ_DATA_W-1:0] req_tdata,
   output wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // row_lines[2:0], column_lines[4:3], gate, step_advanced, zero pad
   output wire logic [gss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [gss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gss_pkg::*;

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;
   logic       req_take;

   gss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_item_ff),
      .fire   (fire),
      .result (result)
   );

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = fire ? 1'b1 : ((rsp_tready) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= item_type'(req_tdata[$bits(item_type)-1:0]);
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(result_type)){1'b0}}, rsp_data_ff};

   `GSS_ASSERT_NOW(a_adv_gate_on, clock, reset,
      rsp_valid_ff && rsp_data_ff.step_advanced, rsp_data_ff.gate,
      "gate low on a step-advance beat")
   `GSS_ASSERT_NOW(a_column_live, clock, reset,
      rsp_valid_ff, rsp_data_ff.column_lines != '0, "no column enabled")
   `GSS_ASSERT_NEXT(a_fire_fills, clock, reset,
      fire, rsp_valid_ff && (rsp_data_ff == $past(result)),
      "processed beat missing from output register")

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

class step_sequencer_board;
   logic [gss_pkg::PERIOD_W-1:0] period_ticks;
   logic [gss_pkg::SWING_W-1:0]  swing_ticks;
   logic [gss_pkg::GATE_W-1:0]   gate_on;
   logic [gss_pkg::GATE_W-1:0]   gate_off;
   logic [gss_pkg::STEPS_W-1:0]  steps_used;

   logic [gss_pkg::TICK_W-1:0] tick_count;
   int                         ext_hold;
   bit                         last_clock;
   int                         step_row;
   logic [gss_pkg::COL_W-1:0]  col_select;
   logic [gss_pkg::COL_W-1:0]  col_drive;
   bit                         odd_beat;
   bit                         prev_mode;

   gss_pkg::result_type expected_q[$];
   int errors, checked, advances, edges_seen, held_ticks, stopped_ticks;

   function new();
      period_ticks = gss_pkg::PERIOD_RESET;
      swing_ticks = gss_pkg::SWING_RESET;
      gate_on = gss_pkg::GATE_RESET;
      gate_off = gss_pkg::GATE_RESET;
      steps_used = gss_pkg::STEP_COUNT_RESET;
      tick_count = '0;
      ext_hold = 0;
      last_clock = 1'b0;
      step_row = 0;
      col_select = gss_pkg::COL_FIRST;
      col_drive = gss_pkg::COL_FIRST;
      odd_beat = 1'b1;
      prev_mode = 1'b0;
   endfunction

   function void write_reg(gss_pkg::csr_reg_type idx, logic [gss_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         gss_pkg::REG_PERIOD: period_ticks = value[gss_pkg::PERIOD_W-1:0];
         gss_pkg::REG_SWING: swing_ticks = value[gss_pkg::SWING_W-1:0];
         gss_pkg::REG_GATE_ON: gate_on = value[gss_pkg::GATE_W-1:0];
         gss_pkg::REG_GATE_OFF: gate_off = value[gss_pkg::GATE_W-1:0];
         gss_pkg::REG_STEP_COUNT: steps_used = value[gss_pkg::STEPS_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // swing lengthens odd beats and shortens even ones, floor at zero
   function int beat_length();
      int e;
      e = odd_beat ? int'(period_ticks) + int'(swing_ticks)
                   : int'(period_ticks) - int'(swing_ticks);
      return (e < 0) ? 0 : e;
   endfunction

   function int gate_length();
      int d, top, margin;
      margin = int'(gss_pkg::MIN_GATE_MARGIN);
      d = odd_beat ? int'(gate_on) : int'(gate_off);
      top = beat_length() - margin;
      if (d < margin) d = margin;
      if (d > top) d = top;
      return (d < 0) ? 0 : d;
   endfunction

   function void note_tick(gss_pkg::item_type it);
      int last, inc, lim, rows;
      bit rising, adv, one_row;
      gss_pkg::result_type r;
      rows = int'(gss_pkg::ROWS_PER_COL);
      one_row = it.mode_1x16;
      inc = it.backward ? -1 : 1;
      if (one_row != prev_mode) begin
         if (one_row) col_select = gss_pkg::COL_FIRST;
         prev_mode = one_row;
      end
      last = int'(steps_used);
      if (last < int'(gss_pkg::MIN_STEPS)) last = int'(gss_pkg::MIN_STEPS);
      if (last > int'(gss_pkg::MAX_STEPS)) last = int'(gss_pkg::MAX_STEPS);
      if (!one_row) last = last / 2;
      tick_count = tick_count + 1'b1;
      rising = it.clock_in && !last_clock;
      last_clock = it.clock_in;
      adv = 1'b0;
      if (!it.not_held) begin
         held_ticks++;
         r.row_lines = 3'(~step_row);
         r.column_lines = col_select;
         r.gate = 1'b0;
         r.step_advanced = 1'b0;
         tick_count = gss_pkg::STOP_PRELOAD;
         // preload so the next advance lands on the first step
         if (it.backward) begin
            if (one_row && last > rows) begin
               step_row = last - rows;
               col_select = gss_pkg::COL_SECOND;
            end else begin
               step_row = last;
               col_select = gss_pkg::COL_FIRST;
            end
         end else begin
            step_row = -1;
            col_select = gss_pkg::COL_FIRST;
         end
         odd_beat = 1'b1;
      end else if (!it.run_enable) begin
         stopped_ticks++;
         col_drive = one_row ? col_select : gss_pkg::COL_BOTH;
         r.row_lines = 3'(~step_row);
         r.column_lines = col_drive;
         r.gate = 1'b1;
         r.step_advanced = 1'b0;
         tick_count = gss_pkg::STOP_PRELOAD;
      end else begin
         if (rising) begin
            ext_hold = int'(gss_pkg::EXT_HOLD_TICKS);
            adv = 1'b1;
            edges_seen++;
         end
         if (ext_hold > 0) ext_hold--;
         if (ext_hold == 0 && int'(tick_count) >= beat_length()) adv = 1'b1;
         if (adv) begin
            advances++;
            odd_beat = !odd_beat;
            tick_count = '0;
            step_row += inc;
            if (!one_row) begin
               if (step_row >= last) step_row = 0;
               else if (step_row <= -1) step_row = last - 1;
            end else if (col_select == gss_pkg::COL_FIRST) begin
               lim = (last < rows) ? last : rows;
               if (step_row >= lim) begin
                  col_select = (last <= rows) ? gss_pkg::COL_FIRST : gss_pkg::COL_SECOND;
                  step_row = 0;
               end else if (step_row <= -1) begin
                  col_select = (last <= rows) ? gss_pkg::COL_FIRST : gss_pkg::COL_SECOND;
                  step_row = (last <= rows) ? last - 1 : last - rows - 1;
               end
            end else begin
               if (rows + step_row >= last) begin
                  col_select = gss_pkg::COL_FIRST;
                  step_row = 0;
               end else if (step_row <= -1) begin
                  col_select = gss_pkg::COL_FIRST;
                  step_row = rows - 1;
               end
            end
            col_drive = one_row ? col_select : gss_pkg::COL_BOTH;
         end
         r.row_lines = 3'(~step_row);
         r.column_lines = col_drive;
         r.gate = (int'(tick_count) <= gate_length());
         r.step_advanced = adv;
      end
      expected_q.push_back(r);
   endfunction

   function void check_output(gss_pkg::result_type got);
      gss_pkg::result_type want;
      if (expected_q.size() == 0) begin
         $error("result beat %h with no tick waiting", got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.row_lines !== want.row_lines) begin
         $error("row_lines: expected %0d, got %0d", want.row_lines, got.row_lines);
         errors++;
      end
      if (got.column_lines !== want.column_lines) begin
         $error("column_lines: expected %0d, got %0d", want.column_lines, got.column_lines);
         errors++;
      end
      if (got.gate !== want.gate) begin
         $error("gate: expected %0d, got %0d", want.gate, got.gate);
         errors++;
      end
      if (got.step_advanced !== want.step_advanced) begin
         $error("step_advanced: expected %0d, got %0d", want.step_advanced, got.step_advanced);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import gss_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   step_sequencer_board board;
   int          req_gap_max = 3;
   int          rsp_stall_max = 3;
   int          rsp_hold = 0;
   bit          cur_back = 1'b0;
   bit          cur_mode = 1'b0;
   int unsigned cycle_count = 0;

   gate_step_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stall after each beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_output(result_type'(rsp_tdata[$bits(result_type)-1:0]));
            rsp_hold = $urandom_range(0, rsp_stall_max);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   function automatic item_type pins(input bit clk, input bit run, input bit nheld,
                                     input bit back, input bit one_row);
      item_type it;
      it.clock_in = clk;
      it.run_enable = run;
      it.not_held = nheld;
      it.backward = back;
      it.mode_1x16 = one_row;
      return it;
   endfunction

   function automatic item_type make_tick(input bit ext_clock, input bit noise);
      item_type it;
      if ($urandom_range(0, 39) == 0) cur_back = !cur_back;
      if ($urandom_range(0, 49) == 0) cur_mode = !cur_mode;
      it.clock_in = ext_clock ? 1'($urandom_range(0, 1)) : 1'b0;
      it.run_enable = noise ? ($urandom_range(0, 19) != 0) : 1'b1;
      it.not_held = noise ? ($urandom_range(0, 29) != 0) : 1'b1;
      it.backward = cur_back;
      it.mode_1x16 = cur_mode;
      return it;
   endfunction

   task automatic send_tick(input item_type it);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_tick(it);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
   endtask

   task automatic set_reg(input csr_reg_type idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      board.write_reg(idx, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic load_settings(input int period, input int swing, input int gon,
                                input int goff, input int steps);
      set_reg(REG_PERIOD, period);
      set_reg(REG_SWING, swing);
      set_reg(REG_GATE_ON, gon);
      set_reg(REG_GATE_OFF, goff);
      set_reg(REG_STEP_COUNT, steps);
      csr_we <= 1'b0;
   endtask

   task automatic run_ticks(input int count, input bit ext_clock, input bit noise);
      req_gap_max = $urandom_range(0, 1) ? 3 : 0;
      rsp_stall_max = $urandom_range(0, 1) ? 3 : 0;
      repeat (count) send_tick(make_tick(ext_clock, noise));
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // internal clock only, no external edge has set the hold yet
      load_settings(2, 1, 1, 0, 16);
      run_ticks(100, 1'b0, 1'b0);
      wait_drained();

      load_settings(4, 2, 2, 1, 16);
      run_ticks(150, 1'b0, 1'b1);
      wait_drained();
      load_settings(0, 0, 0, 0, 1);
      run_ticks(80, 1'b0, 1'b1);
      wait_drained();
      load_settings(3, 4095, 16383, 16383, 0);
      run_ticks(100, 1'b0, 1'b1);
      wait_drained();
      load_settings(7, 3, 5, 3, 31);
      run_ticks(150, 1'b0, 1'b1);
      wait_drained();
      load_settings(16383, 4095, 16383, 0, 9);
      run_ticks(40, 1'b0, 1'b1);
      repeat (4) begin
         wait_drained();
         load_settings($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 31));
         run_ticks(60, 1'b0, 1'b1);
      end

      // directed ticks at reset settings, steps move on clock edges only
      wait_drained();
      load_settings(int'(PERIOD_RESET), int'(SWING_RESET), int'(GATE_RESET),
                    int'(GATE_RESET), int'(STEP_COUNT_RESET));
      send_tick(pins(0, 1, 1, 0, 0));
      send_tick(pins(1, 1, 1, 0, 0));
      send_tick(pins(0, 1, 1, 0, 0));
      send_tick(pins(1, 1, 1, 0, 0));
      send_tick(pins(1, 0, 1, 0, 0));
      send_tick(pins(0, 0, 1, 0, 0));
      send_tick(pins(1, 0, 1, 0, 0));
      send_tick(pins(0, 1, 0, 0, 0));
      send_tick(pins(1, 1, 0, 1, 1));
      send_tick(pins(0, 1, 1, 1, 1));
      send_tick(pins(1, 1, 1, 1, 1));
      send_tick(pins(0, 1, 1, 1, 1));
      send_tick(pins(1, 1, 1, 1, 1));
      send_tick(pins(0, 1, 0, 0, 1));
      send_tick(pins(1, 1, 1, 0, 1));
      send_tick(pins(0, 1, 1, 0, 0));
      send_tick(pins(1, 1, 1, 1, 0));
      send_tick(pins(0, 0, 0, 1, 0));
      send_tick(pins(1, 1, 1, 1, 0));
      send_tick(pins(1, 1, 1, 1, 1));
      send_tick(pins(0, 1, 1, 0, 1));

      // external clock toggling
      wait_drained();
      load_settings(5, 1, 3, 2, $urandom_range(1, 16));
      run_ticks(200, 1'b1, 1'b1);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("checked %0d result beats: %0d step advances, %0d external clock edges",
               board.checked, board.advances, board.edges_seen);
      $display("%0d held ticks, %0d stopped ticks, both modes and directions",
               board.held_ticks, board.stopped_ticks);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
